@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PRS_ASSERT(label, clk, rst_n, prop, msg)
`define PRS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

@@ sv/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// Widths, constants and register codes of the point rotate/scale/project block.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1080;

    localparam int COORD_W  = 24;   // Q16.8 point coordinates
    localparam int SCREEN_W = 32;   // Q24.8 screen coordinates
    localparam int CS_W     = 16;   // Q1.14 cos/sin
    localparam int ROT_W    = 32;
    localparam int MOVE_W   = 24;
    localparam int SCALE_W  = 16;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;

    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_BIAS = 8192;
    localparam int SCALE_SHIFT = 8;
    localparam int SCALE_BIAS  = 128;

    // sum widths per rotation, from magnitude bounds of the operands
    localparam int S1_W = 41;                 // |sum| <= 2^39
    localparam int R1_W = S1_W - FRAC_SHIFT;  // x1, y1
    localparam int S2_W = 42;                 // |sum| < 1.25*2^40 + 2^15
    localparam int R2_W = S2_W - FRAC_SHIFT;  // y2, z1
    localparam int S3_W = 43;                 // |sum| < 1.75*2^41
    localparam int R3_W = S3_W - FRAC_SHIFT;  // x2, z2
    localparam int OFS_W = R3_W + 1;          // after move offset
    localparam int PS_W  = OFS_W + SCALE_W + 1;
    localparam int FIN_W = PS_W - SCALE_SHIFT + 1;

    localparam logic signed [FIN_W-1:0] HALF_X = FIN_W'((SCREEN_WIDTH / 2) * 256);
    localparam logic signed [FIN_W-1:0] HALF_Y = FIN_W'((SCREEN_HEIGHT / 2) * 256);
    localparam logic signed [FIN_W-1:0] SCR_MAX = FIN_W'(64'sd2147483647);
    localparam logic signed [FIN_W-1:0] SCR_MIN = FIN_W'(-64'sd2147483648);
    localparam logic signed [R3_W-1:0]  DEP_MAX = R3_W'(64'sd8388607);
    localparam logic signed [R3_W-1:0]  DEP_MIN = R3_W'(-64'sd8388608);

    localparam int NUM_STAGES = 9;

    typedef enum logic [IDX_W-1:0] {
        IDX_ROT_X = 3'd0,
        IDX_ROT_Y = 3'd1,
        IDX_ROT_Z = 3'd2,
        IDX_MOVE_X = 3'd3,
        IDX_MOVE_Y = 3'd4,
        IDX_SCALE = 3'd5
    } cfg_idx_t;

    localparam logic [ROT_W-1:0]   ROT_RESET   = ROT_W'(16384);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

endpackage

`default_nettype wire

@@ sv/prs_point_if.sv @@
// ----------------------------------------------------------------------------
// prs_point_if
// Point request channel: valid/ready with Q16.8 coordinates and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_point_if;
    import prs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
    logic                      last_in;

    modport source (output valid, output x_in, output y_in, output z_in,
                    output last_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in,
                    input last_in, output ready);
endinterface

`default_nettype wire

@@ sv/prs_result_if.sv @@
// ----------------------------------------------------------------------------
// prs_result_if
// Result request channel: valid/ready with screen X/Y, depth and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_result_if;
    import prs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SCREEN_W-1:0] screen_x;
    logic signed [SCREEN_W-1:0] screen_y;
    logic signed [COORD_W-1:0]  depth_z;
    logic                       last_out;

    modport source (output valid, output screen_x, output screen_y,
                    output depth_z, output last_out, input ready);
    modport sink   (input valid, input screen_x, input screen_y,
                    input depth_z, input last_out, output ready);
endinterface

`default_nettype wire

@@ sv/point_rotate_scale_project.sv @@
// ----------------------------------------------------------------------------
// point_rotate_scale_project
// Rotates a Q16.8 point about Z, X, Y; moves, scales and centers it on screen.
// ----------------------------------------------------------------------------
// Usage:
//   point  : sink of point requests (x_in, y_in, z_in, last_in), valid/ready.
//   result : source of result requests (screen_x, screen_y, depth_z, last_out).
//   cfg_*  : write port; cfg_wr_en writes cfg_data into register cfg_index
//            (0 rot X, 1 rot Y, 2 rot Z, 3 move X, 4 move Y, 5 scale).
//            Other indexes are ignored. Write only while the pipeline is empty.
// Timing:
//   Nine register stages: multiply and round for each of the three rotations,
//   then move, scale multiply, and round/center/saturate. One point per
//   cycle sustained, since every stage takes a new point each cycle while
//   results are taken.
// Reset:
//   Pipeline empties, registers take identity rotation, zero move, scale 1.0.
// Stall:
//   Each stage holds while the one after it is full and held; bubbles still
//   close up, so points keep entering until every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module point_rotate_scale_project (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    prs_point_if.sink                        point,
    prs_result_if.source                     result,
    input  wire logic                        cfg_wr_en,
    input  wire logic [prs_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [prs_pkg::CFG_W-1:0]   cfg_data
);
    import prs_pkg::*;

    // configuration registers
    logic [ROT_W-1:0]   rot_x_reg, rot_y_reg, rot_z_reg;
    logic [MOVE_W-1:0]  move_x_reg, move_y_reg;
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg  <= ROT_RESET;
            rot_y_reg  <= ROT_RESET;
            rot_z_reg  <= ROT_RESET;
            move_x_reg <= '0;
            move_y_reg <= '0;
            scale_reg  <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                IDX_ROT_X:  rot_x_reg  <= cfg_data[ROT_W-1:0];
                IDX_ROT_Y:  rot_y_reg  <= cfg_data[ROT_W-1:0];
                IDX_ROT_Z:  rot_z_reg  <= cfg_data[ROT_W-1:0];
                IDX_MOVE_X: move_x_reg <= cfg_data[MOVE_W-1:0];
                IDX_MOVE_Y: move_y_reg <= cfg_data[MOVE_W-1:0];
                IDX_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    logic signed [CS_W-1:0] cx, sx, cy, sy, cz, sz;
    assign cx = $signed(rot_x_reg[CS_W-1:0]);
    assign sx = $signed(rot_x_reg[ROT_W-1:CS_W]);
    assign cy = $signed(rot_y_reg[CS_W-1:0]);
    assign sy = $signed(rot_y_reg[ROT_W-1:CS_W]);
    assign cz = $signed(rot_z_reg[CS_W-1:0]);
    assign sz = $signed(rot_z_reg[ROT_W-1:CS_W]);

    // stage valids and advance enables
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign point.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= point.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0: Z rotation products
    logic signed [S1_W-1:0]    s0_xc_reg, s0_ys_reg, s0_xs_reg, s0_yc_reg;
    logic signed [S1_W-1:0]    s0_xc_next, s0_ys_next, s0_xs_next, s0_yc_next;
    logic signed [COORD_W-1:0] s0_z_reg;
    logic                      s0_last_reg;

    always_comb
    begin
        s0_xc_next = S1_W'(point.x_in) * S1_W'(cz);
        s0_ys_next = S1_W'(point.y_in) * S1_W'(sz);
        s0_xs_next = S1_W'(point.x_in) * S1_W'(sz);
        s0_yc_next = S1_W'(point.y_in) * S1_W'(cz);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_xc_reg   <= s0_xc_next;
            s0_ys_reg   <= s0_ys_next;
            s0_xs_reg   <= s0_xs_next;
            s0_yc_reg   <= s0_yc_next;
            s0_z_reg    <= point.z_in;
            s0_last_reg <= point.last_in;
        end
    end

    // stage 1: Z rotation sums, rounded
    logic signed [S1_W-1:0]    s1_xsum, s1_ysum;
    logic signed [R1_W-1:0]    s1_x1_next, s1_y1_next;
    logic signed [R1_W-1:0]    s1_x1_reg, s1_y1_reg;
    logic signed [COORD_W-1:0] s1_z_reg;
    logic                      s1_last_reg;

    always_comb
    begin
        s1_xsum    = s0_xc_reg - s0_ys_reg + S1_W'(ROUND_BIAS);
        s1_ysum    = s0_xs_reg + s0_yc_reg + S1_W'(ROUND_BIAS);
        s1_x1_next = $signed(s1_xsum[S1_W-1:FRAC_SHIFT]);
        s1_y1_next = $signed(s1_ysum[S1_W-1:FRAC_SHIFT]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_x1_reg   <= s1_x1_next;
            s1_y1_reg   <= s1_y1_next;
            s1_z_reg    <= s0_z_reg;
            s1_last_reg <= s0_last_reg;
        end
    end

    // stage 2: X rotation products
    logic signed [S2_W-1:0] s2_yc_next, s2_zs_next, s2_ys_next, s2_zc_next;
    logic signed [S2_W-1:0] s2_yc_reg, s2_zs_reg, s2_ys_reg, s2_zc_reg;
    logic signed [R1_W-1:0] s2_x1_reg;
    logic                   s2_last_reg;

    always_comb
    begin
        s2_yc_next = S2_W'(s1_y1_reg) * S2_W'(cx);
        s2_zs_next = S2_W'(s1_z_reg) * S2_W'(sx);
        s2_ys_next = S2_W'(s1_y1_reg) * S2_W'(sx);
        s2_zc_next = S2_W'(s1_z_reg) * S2_W'(cx);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_yc_reg   <= s2_yc_next;
            s2_zs_reg   <= s2_zs_next;
            s2_ys_reg   <= s2_ys_next;
            s2_zc_reg   <= s2_zc_next;
            s2_x1_reg   <= s1_x1_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: X rotation sums, rounded
    logic signed [S2_W-1:0] s3_ysum, s3_zsum;
    logic signed [R2_W-1:0] s3_y2_next, s3_z1_next;
    logic signed [R2_W-1:0] s3_y2_reg, s3_z1_reg;
    logic signed [R1_W-1:0] s3_x1_reg;
    logic                   s3_last_reg;

    always_comb
    begin
        s3_ysum    = s2_yc_reg - s2_zs_reg + S2_W'(ROUND_BIAS);
        s3_zsum    = s2_ys_reg + s2_zc_reg + S2_W'(ROUND_BIAS);
        s3_y2_next = $signed(s3_ysum[S2_W-1:FRAC_SHIFT]);
        s3_z1_next = $signed(s3_zsum[S2_W-1:FRAC_SHIFT]);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_y2_reg   <= s3_y2_next;
            s3_z1_reg   <= s3_z1_next;
            s3_x1_reg   <= s2_x1_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // stage 4: Y rotation products
    logic signed [S3_W-1:0] s4_xc_next, s4_zs_next, s4_zc_next, s4_xs_next;
    logic signed [S3_W-1:0] s4_xc_reg, s4_zs_reg, s4_zc_reg, s4_xs_reg;
    logic signed [R2_W-1:0] s4_y2_reg;
    logic                   s4_last_reg;

    always_comb
    begin
        s4_xc_next = S3_W'(s3_x1_reg) * S3_W'(cy);
        s4_zs_next = S3_W'(s3_z1_reg) * S3_W'(sy);
        s4_zc_next = S3_W'(s3_z1_reg) * S3_W'(cy);
        s4_xs_next = S3_W'(s3_x1_reg) * S3_W'(sy);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_xc_reg   <= s4_xc_next;
            s4_zs_reg   <= s4_zs_next;
            s4_zc_reg   <= s4_zc_next;
            s4_xs_reg   <= s4_xs_next;
            s4_y2_reg   <= s3_y2_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // stage 5: Y rotation sums, rounded
    logic signed [S3_W-1:0] s5_xsum, s5_zsum;
    logic signed [R3_W-1:0] s5_x2_next, s5_z2_next;
    logic signed [R3_W-1:0] s5_x2_reg, s5_z2_reg;
    logic signed [R2_W-1:0] s5_y2_reg;
    logic                   s5_last_reg;

    always_comb
    begin
        s5_xsum    = s4_xc_reg + s4_zs_reg + S3_W'(ROUND_BIAS);
        s5_zsum    = s4_zc_reg - s4_xs_reg + S3_W'(ROUND_BIAS);
        s5_x2_next = $signed(s5_xsum[S3_W-1:FRAC_SHIFT]);
        s5_z2_next = $signed(s5_zsum[S3_W-1:FRAC_SHIFT]);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_x2_reg   <= s5_x2_next;
            s5_z2_reg   <= s5_z2_next;
            s5_y2_reg   <= s4_y2_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // stage 6: move offsets, depth saturation
    logic signed [OFS_W-1:0]   s6_ox_next, s6_oy_next;
    logic signed [OFS_W-1:0]   s6_ox_reg, s6_oy_reg;
    logic signed [COORD_W-1:0] s6_dz_next, s6_dz_reg;
    logic                      s6_last_reg;

    always_comb
    begin
        s6_ox_next = OFS_W'(s5_x2_reg) + OFS_W'($signed(move_x_reg));
        s6_oy_next = OFS_W'(s5_y2_reg) + OFS_W'($signed(move_y_reg));
        if (s5_z2_reg > DEP_MAX)
        begin
            s6_dz_next = DEP_MAX[COORD_W-1:0];
        end
        else if (s5_z2_reg < DEP_MIN)
        begin
            s6_dz_next = DEP_MIN[COORD_W-1:0];
        end
        else
        begin
            s6_dz_next = s5_z2_reg[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_ox_reg   <= s6_ox_next;
            s6_oy_reg   <= s6_oy_next;
            s6_dz_reg   <= s6_dz_next;
            s6_last_reg <= s5_last_reg;
        end
    end

    // stage 7: zoom
    logic signed [PS_W-1:0]    s7_px_next, s7_py_next;
    logic signed [PS_W-1:0]    s7_px_reg, s7_py_reg;
    logic signed [PS_W-1:0]    scale_ext;
    logic signed [COORD_W-1:0] s7_dz_reg;
    logic                      s7_last_reg;

    always_comb
    begin
        scale_ext  = PS_W'($signed({1'b0, scale_reg}));
        s7_px_next = PS_W'(s6_ox_reg) * scale_ext;
        s7_py_next = PS_W'(s6_oy_reg) * scale_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_px_reg   <= s7_px_next;
            s7_py_reg   <= s7_py_next;
            s7_dz_reg   <= s6_dz_reg;
            s7_last_reg <= s6_last_reg;
        end
    end

    // stage 8: round, center, saturate
    logic signed [PS_W-1:0]     s8_px_rnd, s8_py_rnd;
    logic signed [FIN_W-1:0]    s8_fx, s8_fy;
    logic signed [SCREEN_W-1:0] s8_sx_next, s8_sy_next;
    logic signed [SCREEN_W-1:0] s8_sx_reg, s8_sy_reg;
    logic signed [COORD_W-1:0]  s8_dz_reg;
    logic                       s8_last_reg;

    always_comb
    begin
        s8_px_rnd = s7_px_reg + PS_W'(SCALE_BIAS);
        s8_py_rnd = s7_py_reg + PS_W'(SCALE_BIAS);
        s8_fx = FIN_W'($signed(s8_px_rnd[PS_W-1:SCALE_SHIFT])) + HALF_X;
        s8_fy = FIN_W'($signed(s8_py_rnd[PS_W-1:SCALE_SHIFT])) + HALF_Y;
        if (s8_fx > SCR_MAX)
        begin
            s8_sx_next = SCR_MAX[SCREEN_W-1:0];
        end
        else if (s8_fx < SCR_MIN)
        begin
            s8_sx_next = SCR_MIN[SCREEN_W-1:0];
        end
        else
        begin
            s8_sx_next = s8_fx[SCREEN_W-1:0];
        end
        if (s8_fy > SCR_MAX)
        begin
            s8_sy_next = SCR_MAX[SCREEN_W-1:0];
        end
        else if (s8_fy < SCR_MIN)
        begin
            s8_sy_next = SCR_MIN[SCREEN_W-1:0];
        end
        else
        begin
            s8_sy_next = s8_fy[SCREEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_sx_reg   <= s8_sx_next;
            s8_sy_reg   <= s8_sy_next;
            s8_dz_reg   <= s7_dz_reg;
            s8_last_reg <= s7_last_reg;
        end
    end

    assign result.valid    = v_reg[NUM_STAGES-1];
    assign result.screen_x = s8_sx_reg;
    assign result.screen_y = s8_sy_reg;
    assign result.depth_z  = s8_dz_reg;
    assign result.last_out = s8_last_reg;

    // an accepted point occupies stage 0 with its flag
    `PRS_ASSERT(a_accept_lands, clk, rst_n, (point.valid && point.ready) |=> (v_reg[0] && (s0_last_reg == $past(point.last_in))), "accepted point not captured")
    // full pipeline behind a stalled output takes nothing
    `PRS_ASSERT_NEVER(a_full_no_accept, clk, rst_n, (&v_reg) && !result.ready && point.ready, "point accepted into a full pipeline")
    // stage 0, when held, keeps its item
    `PRS_ASSERT(a_stage0_hold, clk, rst_n, (v_reg[0] && !en[1]) |=> (v_reg[0] && $stable(s0_z_reg) && $stable(s0_last_reg)), "held stage lost its point")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Point rotate/scale/project block: directed corner points, then randomized
// phases of points under random register settings. Every result is checked
// field by field against an in-order prediction. Both handshake sides idle
// at random; the result side also holds off long enough to back up the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prs_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = NUM_STAGES * 4;
    localparam int RANDOM_ITEMS = 600;

    localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } map_point_t;

    typedef struct packed {
        logic signed [SCREEN_W-1:0] sx;
        logic signed [SCREEN_W-1:0] sy;
        logic signed [COORD_W-1:0]  dz;
        logic                       last;
    } screen_point_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    prs_point_if  point_ch ();
    prs_result_if result_ch ();

    point_rotate_scale_project DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register shadow
    logic [ROT_W-1:0]   rot_x_cs = ROT_RESET;
    logic [ROT_W-1:0]   rot_y_cs = ROT_RESET;
    logic [ROT_W-1:0]   rot_z_cs = ROT_RESET;
    logic [MOVE_W-1:0]  shift_x  = '0;
    logic [MOVE_W-1:0]  shift_y  = '0;
    logic [SCALE_W-1:0] zoom     = SCALE_RESET;

    map_point_t    pending_points[$];
    screen_point_t expected_screen[$];

    int mismatches   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int send_wait    = 0;
    int recv_wait    = 0;
    int long_holds   = 0;
    bit send_calm    = 1'b1;
    bit recv_calm    = 1'b1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic screen_point_t project_point(map_point_t p);
        longint px, py, pz, cx, sx, cy, sy, cz, sz, scl;
        longint x1, y1, y2, z1, x2, z2, vx, vy;
        screen_point_t r;
        px  = longint'($signed(p.x));
        py  = longint'($signed(p.y));
        pz  = longint'($signed(p.z));
        cx  = longint'($signed(rot_x_cs[CS_W-1:0]));
        sx  = longint'($signed(rot_x_cs[ROT_W-1:CS_W]));
        cy  = longint'($signed(rot_y_cs[CS_W-1:0]));
        sy  = longint'($signed(rot_y_cs[ROT_W-1:CS_W]));
        cz  = longint'($signed(rot_z_cs[CS_W-1:0]));
        sz  = longint'($signed(rot_z_cs[ROT_W-1:CS_W]));
        scl = longint'(zoom);

        x1 = (px * cz - py * sz + ROUND_BIAS) >>> FRAC_SHIFT;
        y1 = (px * sz + py * cz + ROUND_BIAS) >>> FRAC_SHIFT;
        y2 = (y1 * cx - pz * sx + ROUND_BIAS) >>> FRAC_SHIFT;
        z1 = (y1 * sx + pz * cx + ROUND_BIAS) >>> FRAC_SHIFT;
        x2 = (x1 * cy + z1 * sy + ROUND_BIAS) >>> FRAC_SHIFT;
        z2 = (z1 * cy - x1 * sy + ROUND_BIAS) >>> FRAC_SHIFT;

        vx = (((x2 + longint'($signed(shift_x))) * scl + SCALE_BIAS) >>> SCALE_SHIFT)
             + longint'(SCREEN_WIDTH / 2) * 256;
        vy = (((y2 + longint'($signed(shift_y))) * scl + SCALE_BIAS) >>> SCALE_SHIFT)
             + longint'(SCREEN_HEIGHT / 2) * 256;

        r.sx   = SCREEN_W'(clamp_to(vx, -64'sd2147483648, 64'sd2147483647));
        r.sy   = SCREEN_W'(clamp_to(vy, -64'sd2147483648, 64'sd2147483647));
        r.dz   = COORD_W'(clamp_to(z2, -64'sd8388608, 64'sd8388607));
        r.last = p.last;
        return r;
    endfunction

    task automatic flag_mismatch(string field, longint want, longint got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // point request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            point_ch.valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                expected_screen.push_back(project_point(pending_points.pop_front()));
                send_wait = send_calm ? 0 : $urandom_range(0, 11);
            end
            if (!point_ch.valid || point_ch.ready)
            begin
                if (send_wait > 0 || pending_points.size() == 0)
                begin
                    point_ch.valid <= 1'b0;
                    if (send_wait > 0)
                        send_wait--;
                end
                else
                begin
                    point_ch.valid   <= 1'b1;
                    point_ch.x_in    <= pending_points[0].x;
                    point_ch.y_in    <= pending_points[0].y;
                    point_ch.z_in    <= pending_points[0].z;
                    point_ch.last_in <= pending_points[0].last;
                end
            end
        end
    end

    // result request monitor
    always @(posedge clk)
    begin
        screen_point_t got;
        screen_point_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.sx   = result_ch.screen_x;
                got.sy   = result_ch.screen_y;
                got.dz   = result_ch.depth_z;
                got.last = result_ch.last_out;
                results_seen++;
                if (expected_screen.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got x %0d y %0d z %0d",
                             $time, got.sx, got.sy, got.dz);
                    mismatches++;
                end
                else
                begin
                    want = expected_screen.pop_front();
                    if (got.sx !== want.sx)
                        flag_mismatch("screen_x", want.sx, got.sx);
                    if (got.sy !== want.sy)
                        flag_mismatch("screen_y", want.sy, got.sy);
                    if (got.dz !== want.dz)
                        flag_mismatch("depth_z", want.dz, got.dz);
                    if (got.last !== want.last)
                        flag_mismatch("last_out", want.last, got.last);
                end
                recv_wait = recv_calm ? 0 : $urandom_range(0, 11);
                // long hold-off while points keep coming: pipe fills and input stalls
                if (pending_points.size() > 2 * NUM_STAGES
                    && ((long_holds == 0 && results_seen >= 120)
                        || (long_holds == 1 && results_seen >= 450)))
                begin
                    recv_wait = LONG_HOLD;
                    long_holds++;
                end
            end
            if (recv_wait > 0)
            begin
                result_ch.ready <= 1'b0;
                recv_wait--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic set_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            IDX_ROT_X:  rot_x_cs = data;
            IDX_ROT_Y:  rot_y_cs = data;
            IDX_ROT_Z:  rot_z_cs = data;
            IDX_MOVE_X: shift_x  = data[MOVE_W-1:0];
            IDX_MOVE_Y: shift_y  = data[MOVE_W-1:0];
            IDX_SCALE:  zoom     = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_config();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || expected_screen.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z, input logic last);
        map_point_t p;
        p.x    = x;
        p.y    = y;
        p.z    = z;
        p.last = last;
        pending_points.push_back(p);
    endtask

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 3))
            0: return COORD_W'($urandom());
            1: return COORD_W'(int'($urandom_range(0, 131070)) - 65535);
            2: return COORD_W'(int'($urandom_range(0, 2046)) - 1023);
            default:
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    function automatic logic [ROT_W-1:0] random_rotation();
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: begin c = 16384; s = 0;     end
            2: begin c = 15137; s = 6270;  end
            3: begin c = 11585; s = 11585; end
            4: begin c = 6270;  s = 15137; end
            default: begin c = 0; s = 16384; end
        endcase
        if ($urandom_range(0, 1))
            c = -c;
        if ($urandom_range(0, 1))
            s = -s;
        return {s, c};
    endfunction

    // upper bits stay random: they must be ignored
    function automatic logic [CFG_W-1:0] random_move();
        logic [CFG_W-1:0] d;
        d = $urandom();
        if ($urandom_range(0, 3) != 0)
            d[MOVE_W-1:0] = MOVE_W'(int'($urandom_range(0, 524288)) - 262144);
        return d;
    endfunction

    function automatic logic [CFG_W-1:0] random_scale();
        logic [CFG_W-1:0] d;
        d = $urandom();
        case ($urandom_range(0, 3))
            0: ;
            1: d[SCALE_W-1:0] = SCALE_RESET;
            default: d[SCALE_W-1:0] = SCALE_W'($urandom_range(64, 1024));
        endcase
        return d;
    endfunction

    task automatic run_random_phase(input int count, input bit calm);
        wait_drained();
        send_calm = calm ? 1'b1 : ($urandom_range(0, 3) == 0);
        recv_calm = calm ? 1'b1 : ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1))
            set_register(IDX_ROT_X, random_rotation());
        if ($urandom_range(0, 1))
            set_register(IDX_ROT_Y, random_rotation());
        if ($urandom_range(0, 1))
            set_register(IDX_ROT_Z, random_rotation());
        if ($urandom_range(0, 1))
            set_register(IDX_MOVE_X, random_move());
        if ($urandom_range(0, 1))
            set_register(IDX_MOVE_Y, random_move());
        if ($urandom_range(0, 1))
            set_register(IDX_SCALE, random_scale());
        if ($urandom_range(0, 7) == 0)
            set_register($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom());
        end_config();
        repeat (count)
            queue_point(random_coord(), random_coord(), random_coord(), $urandom_range(0, 1));
    endtask

    initial
    begin
        int queued;
        int n;
        rst_n            = 1'b0;
        point_ch.valid   = 1'b0;
        point_ch.x_in    = '0;
        point_ch.y_in    = '0;
        point_ch.z_in    = '0;
        point_ch.last_in = 1'b0;
        result_ch.ready  = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: identity rotation, no move, unit zoom
        queue_point('0, '0, '0, 1'b0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, COORD_MIN, '0, 1'b1);
        queue_point('1, '1, '1, 1'b0);
        queue_point(24'sd1, '0, '0, 1'b0);
        queue_point(24'sd256, -24'sd256, 24'sd128, 1'b1);

        // largest pairs off the unit circle, top move and zoom: saturation high
        wait_drained();
        set_register(IDX_ROT_X, 32'h7FFF_7FFF);
        set_register(IDX_ROT_Y, 32'h7FFF_7FFF);
        set_register(IDX_ROT_Z, 32'h7FFF_7FFF);
        set_register(IDX_MOVE_X, 32'hFF7F_FFFF);
        set_register(IDX_MOVE_Y, 32'h007F_FFFF);
        set_register(IDX_SCALE, 32'hFFFF_FFFF);
        set_register(IDX_SPARE_A, 32'h0000_0000);
        set_register(IDX_SPARE_B, 32'hFFFF_FFFF);
        end_config();
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        queue_point('0, '0, '0, 1'b0);
        queue_point(COORD_MAX, '0, COORD_MIN, 1'b1);
        queue_point(24'sd1, -24'sd1, 24'sd1, 1'b0);
        queue_point(COORD_MIN, COORD_MAX, '0, 1'b0);

        // most negative pairs, bottom move, zero zoom
        wait_drained();
        set_register(IDX_ROT_X, 32'h8000_8000);
        set_register(IDX_ROT_Y, 32'h8000_8000);
        set_register(IDX_ROT_Z, 32'h8000_8000);
        set_register(IDX_MOVE_X, 32'h0080_0000);
        set_register(IDX_MOVE_Y, 32'hAA80_0000);
        set_register(IDX_SCALE, 32'h1234_0000);
        end_config();
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point('0, '0, COORD_MAX, 1'b0);
        queue_point('1, COORD_MAX, COORD_MIN, 1'b1);
        queue_point(24'sd1000, -24'sd1000, 24'sd5, 1'b0);

        // depth overflow through a doubled cosine
        wait_drained();
        set_register(IDX_ROT_X, 32'h0000_7FFF);
        set_register(IDX_ROT_Y, 32'hC000_4000);
        set_register(IDX_ROT_Z, ROT_RESET);
        set_register(IDX_MOVE_X, 32'h0000_0000);
        set_register(IDX_MOVE_Y, 32'h0000_0100);
        set_register(IDX_SCALE, SCALE_RESET);
        end_config();
        queue_point('0, '0, COORD_MAX, 1'b0);
        queue_point('0, '0, COORD_MIN, 1'b1);
        queue_point(COORD_MAX, '0, '0, 1'b0);
        queue_point(COORD_MIN, '0, '0, 1'b1);

        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            n = $urandom_range(30, 70);
            run_random_phase(n, queued == 0);
            queued += n;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
